### src/mtg_pkg.sv
// Package with the constants and word functions of the generator.
`timescale 1ns / 1ps

package mtg_pkg;

  localparam int unsigned STATE_WORDS  = 624;
  localparam int unsigned TWIST_OFFSET = 397;
  localparam int unsigned IDX_W        = 10;

  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(STATE_WORDS - 1);
  localparam logic [IDX_W-1:0] WRAP_IDX  = IDX_W'(STATE_WORDS - TWIST_OFFSET);
  localparam logic [IDX_W-1:0] FAR_STEP  = IDX_W'(TWIST_OFFSET);

  localparam logic [31:0] TWIST_MATRIX = 32'h9908_b0df;
  localparam logic [31:0] HIGH_BIT     = 32'h8000_0000;
  localparam logic [31:0] LOW_BITS     = 32'h7fff_ffff;
  localparam logic [31:0] FILL_MULT    = 32'd1812433253;
  localparam logic [31:0] SEED_DEFAULT = 32'd5489;
  localparam logic [31:0] TEMPER_B     = 32'h9d2c_5680;
  localparam logic [31:0] TEMPER_C     = 32'hefc6_0000;

  typedef logic [31:0]      word_t;
  typedef logic [IDX_W-1:0] idx_t;

  // New value of one state word from its own old value, the following word and
  // the word at the twist offset.
  function automatic word_t twist_word(input word_t cur, input word_t nxt, input word_t far);
    word_t y;
    word_t v;
    y = (cur & HIGH_BIT) | (nxt & LOW_BITS);
    v = far ^ (y >> 1);
    if (y[0]) begin
      v = v ^ TWIST_MATRIX;
    end
    return v;
  endfunction

  function automatic word_t temper(input word_t w);
    word_t y;
    y = w;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

### src/mersenne_twister_generator.sv
// Top level of the 32-bit Mersenne Twister generator.
//
// Every transfer on the in_ channel is a request for one word; the word comes
// back as one transfer on the out_ channel. in_tdata bit 0 is the restart
// flag: when set, the state is refilled from the seed before the draw.
// cfg_data writes the seed register; the next request then refills the state.
// Reset sets the seed to 5489 and marks the state as unfilled, so the first
// request after reset or after a seed write also refills it.
// The state words sit in a RAM with two read ports. A draw reads the word one
// place on and the word 397 places on, twists the current word in place,
// writes it back and tempers it into the output register that drives
// out_tvalid. No new request is taken until the draw is done: the RAM read is
// registered on the way into the draw state, and the write back is made in it.
// A refill writes one word per cycle through the seeding multiplier, 624 words
// in all, and then passes through a read state before the draw of that request.
// The result waits in an output register while out_tready is low; a new
// request is taken once that register is free or is drained in the same cycle.
`timescale 1ns / 1ps

module mersenne_twister_generator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [0] restart, [7:1] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] random_word
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  import mtg_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_FILL = 2'd1;
  localparam logic [1:0] ST_READ = 2'd2;
  localparam logic [1:0] ST_DRAW = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       filled_r, filled_nxt;
  idx_t       k_r, k_nxt;
  word_t      seed_r, seed_nxt;
  word_t      prev_r, prev_nxt;   // last word written during a refill
  word_t      cur_r, cur_nxt;     // old value of the word to be drawn next
  logic       out_valid_r, out_valid_nxt;
  word_t      out_data_r, out_data_nxt;

  logic       in_xfer;
  idx_t       rd_next_addr;
  idx_t       rd_far_addr;
  word_t      rd_next_data;
  word_t      rd_far_data;
  logic       wr_en;
  word_t      wr_data;
  word_t      fill_mix;
  word_t      fill_word;
  word_t      twisted;

  assign in_tready  = (state_r == ST_IDLE) && (!out_valid_r || out_tready);
  assign in_xfer    = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Read addresses follow the draw index all the time; the RAM registers them
  // at the edge that moves into the draw cycle.
  assign rd_next_addr = (k_r == LAST_IDX) ? '0 : k_r + idx_t'(1);
  assign rd_far_addr  = (k_r >= WRAP_IDX) ? k_r - WRAP_IDX : k_r + FAR_STEP;

  assign fill_mix  = prev_r ^ (prev_r >> 30);
  assign fill_word = (k_r == '0) ? seed_r : (FILL_MULT * fill_mix) + word_t'(k_r);
  assign twisted   = twist_word(cur_r, rd_next_data, rd_far_data);

  assign wr_en   = (state_r == ST_FILL) || (state_r == ST_DRAW);
  assign wr_data = (state_r == ST_FILL) ? fill_word : twisted;

  mtg_ram #(
    .WIDTH(32),
    .DEPTH(STATE_WORDS)
  ) u_state_ram (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (k_r),
    .wr_data   (wr_data),
    .rd_addr_a (rd_next_addr),
    .rd_data_a (rd_next_data),
    .rd_addr_b (rd_far_addr),
    .rd_data_b (rd_far_data)
  );

  always_comb begin
    state_nxt     = state_r;
    filled_nxt    = filled_r;
    k_nxt         = k_r;
    seed_nxt      = seed_r;
    prev_nxt      = prev_r;
    cur_nxt       = cur_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_valid && cfg_ready) begin
      seed_nxt   = cfg_data;
      filled_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          if (in_tdata[0] || !filled_r) begin
            state_nxt = ST_FILL;
            k_nxt     = '0;
          end else begin
            state_nxt = ST_DRAW;
          end
        end
      end
      ST_FILL: begin
        prev_nxt = fill_word;
        if (k_r == '0) begin
          cur_nxt = fill_word;
        end
        if (k_r == LAST_IDX) begin
          k_nxt      = '0;
          filled_nxt = 1'b1;
          state_nxt  = ST_READ;
        end else begin
          k_nxt = k_r + idx_t'(1);
        end
      end
      ST_READ: begin
        state_nxt = ST_DRAW;
      end
      ST_DRAW: begin
        cur_nxt       = rd_next_data;
        out_valid_nxt = 1'b1;
        out_data_nxt  = temper(twisted);
        k_nxt         = rd_next_addr;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      filled_r    <= 1'b0;
      k_r         <= '0;
      seed_r      <= SEED_DEFAULT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      filled_r    <= filled_nxt;
      k_r         <= k_nxt;
      seed_r      <= seed_nxt;
      out_valid_r <= out_valid_nxt;
    end
    prev_r     <= prev_nxt;
    cur_r      <= cur_nxt;
    out_data_r <= out_data_nxt;
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk) disable iff (!rst_n) k_r <= LAST_IDX)
    else $error("state word index out of range");

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DRAW) |=> (out_valid_r && (state_r == ST_IDLE)))
    else $error("draw did not load the output register");

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DRAW) |-> !out_valid_r)
    else $error("draw would overwrite a pending result");

  assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_FILL) && (k_r == LAST_IDX)) |=> ((state_r == ST_READ) && (k_r == '0)))
    else $error("refill did not end at the first word");

  assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && !in_tdata[0] && filled_r) |=> (state_r == ST_DRAW))
    else $error("request on a filled state did not draw at once");
`endif

endmodule

### src/mtg_ram.sv
// Generic RAM with one write port and two registered read ports.
`timescale 1ns / 1ps

module mtg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 624
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
  output logic [WIDTH-1:0]         rd_data_a,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule
